### rtl/core/fnv1a_change_detector_macros.svh
// ----------------------------------------------------------------------------
// FNV-1a change detector: assertion macros
// Shared property shapes for the port checker; clk and rst_n must be in scope.
// ----------------------------------------------------------------------------
`ifndef FNV1A_CHANGE_DETECTOR_MACROS_SVH
`define FNV1A_CHANGE_DETECTOR_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define FCD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcd: same-cycle property failed");

// consequent must hold in the cycle after the antecedent
`define FCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcd: next-cycle property failed");

`endif

### rtl/core/fcd_pkg.sv
// ----------------------------------------------------------------------------
// FNV-1a change detector: package
// Word types, limits and the FNV-1a 64-bit prime multiply.
// ----------------------------------------------------------------------------
`default_nettype none

package fcd_pkg;

    localparam int unsigned DATA_W               = 64;
    localparam int unsigned COUNT_W              = 13;
    localparam int unsigned REQ_W                = 16;
    localparam int unsigned RECORD_LIMIT         = 4096;
    localparam int unsigned WORDS_PER_RECORD_DEF = 8;

    localparam logic [COUNT_W-1:0] COUNT_LIMIT     = 13'd4096;
    localparam logic [COUNT_W-1:0] MAX_RECORDS_RST = 13'd1024;
    localparam logic [DATA_W-1:0]  FNV_BASIS       = 64'hcbf2_9ce4_8422_2325;

    typedef struct packed {
        logic [DATA_W-1:0] payload_word;
        logic              has_word;
        logic              first_item;
        logic              last_item;
        logic [REQ_W-1:0]  requested_records;
    } in_word_t;

    typedef struct packed {
        logic               upload_needed;
        logic [DATA_W-1:0]  fingerprint;
        logic [COUNT_W-1:0] kept_records;
        logic               truncated;
    } out_word_t;

    // word after the seed stage
    typedef struct packed {
        logic [DATA_W-1:0]  payload_word;
        logic               has_word;
        logic               first_item;
        logic               last_item;
        logic [COUNT_W-1:0] kept_records;
        logic               truncated;
        logic [DATA_W-1:0]  seed_hash;
    } seed_t;

    // closed frame waiting for the decision
    typedef struct packed {
        logic [DATA_W-1:0]  fingerprint;
        logic [COUNT_W-1:0] kept_records;
        logic               truncated;
    } frame_t;

    // prime is 2^40 + 0x1b3: shift-add form, modulo 2^64
    function automatic logic [DATA_W-1:0] fnv_mul(input logic [DATA_W-1:0] x);
        fnv_mul = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

`default_nettype wire

### rtl/core/fnv1a_change_detector.sv
// ----------------------------------------------------------------------------
// FNV-1a change detector: top level
// Fingerprints frames of 64-bit record words and flags frames that changed.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------
//   in       | in_valid / in_stall  | in_data   (fcd_pkg::in_word_t)
//   out      | out_valid / out_stall| out_data  (fcd_pkg::out_word_t)
//   cfg      | cfg_write            | cfg_data  (max_records, 13 bits)
//
// One word is taken every cycle while in_stall is low; the result of a last
// word passes the seed register, the fold register and the output register.
// The fold register closes the running-hash loop: one XOR and one prime
// multiply per cycle. Reset is asynchronous; no clearing pass is needed.
// in_stall rises only while a last word waits in the seed register, a closed
// frame waits in the fold register and out_stall holds the result ahead of it.
// ----------------------------------------------------------------------------
`default_nettype none

module fnv1a_change_detector #(
    parameter int unsigned WORDS_PER_RECORD = fcd_pkg::WORDS_PER_RECORD_DEF
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           cfg_write,
    input  wire  [fcd_pkg::COUNT_W-1:0]   cfg_data,
    input  wire                           in_valid,
    output logic                          in_stall,
    input  fcd_pkg::in_word_t             in_data,
    output logic                          out_valid,
    input  wire                           out_stall,
    output fcd_pkg::out_word_t            out_data
);

    import fcd_pkg::*;

    localparam int unsigned WL_W = $clog2(RECORD_LIMIT * WORDS_PER_RECORD + 1);

    logic            stage_valid;
    seed_t           stage_data;
    logic [WL_W-1:0] stage_limit;
    logic            take;
    logic            out_free;
    logic            res_valid;
    frame_t          res_data;

    fcd_seed #(
        .WORDS_PER_RECORD (WORDS_PER_RECORD)
    ) u_seed (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .take        (take),
        .stage_valid (stage_valid),
        .stage_data  (stage_data),
        .stage_limit (stage_limit)
    );

    fcd_fold #(
        .WORDS_PER_RECORD (WORDS_PER_RECORD)
    ) u_fold (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid),
        .stage_data  (stage_data),
        .stage_limit (stage_limit),
        .take        (take),
        .out_free    (out_free),
        .res_valid   (res_valid),
        .res_data    (res_data)
    );

    fcd_decide u_decide (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_data  (res_data),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

### rtl/core/fcd_seed.sv
// ----------------------------------------------------------------------------
// FNV-1a change detector: seed stage
// Holds max_records, limits the requested count and precomputes the seed
// hash and word limit of a possible frame start into the stage register.
// ----------------------------------------------------------------------------
`default_nettype none

module fcd_seed #(
    parameter int unsigned WORDS_PER_RECORD = fcd_pkg::WORDS_PER_RECORD_DEF,
    localparam int unsigned WL_W =
        $clog2(fcd_pkg::RECORD_LIMIT * WORDS_PER_RECORD + 1)
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           cfg_write,
    input  wire  [fcd_pkg::COUNT_W-1:0]   cfg_data,
    input  wire                           in_valid,
    output logic                          in_stall,
    input  fcd_pkg::in_word_t             in_data,
    input  wire                           take,
    output logic                          stage_valid,
    output fcd_pkg::seed_t                stage_data,
    output logic [WL_W-1:0]               stage_limit
);

    import fcd_pkg::*;

    logic [COUNT_W-1:0] max_records_reg;
    logic               valid_reg;
    seed_t              data_reg;
    logic [WL_W-1:0]    limit_reg;

    logic [COUNT_W-1:0] rec_limit;
    logic               over;
    logic [COUNT_W-1:0] kept;
    seed_t              data_next;
    logic [WL_W-1:0]    limit_next;
    logic               ready;
    logic               accept;

    always_comb
    begin
        rec_limit = (max_records_reg > COUNT_LIMIT) ? COUNT_LIMIT : max_records_reg;
        over      = in_data.requested_records > REQ_W'(rec_limit);
        kept      = over ? rec_limit : in_data.requested_records[COUNT_W-1:0];

        data_next.payload_word = in_data.payload_word;
        data_next.has_word     = in_data.has_word;
        data_next.first_item   = in_data.first_item;
        data_next.last_item    = in_data.last_item;
        data_next.kept_records = kept;
        data_next.truncated    = over;
        data_next.seed_hash    = fnv_mul(FNV_BASIS ^ DATA_W'(kept));

        limit_next = WL_W'(kept) * WL_W'(WORDS_PER_RECORD);
    end

    assign ready    = !valid_reg || take;
    assign accept   = in_valid && ready;
    assign in_stall = !ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_records_reg <= MAX_RECORDS_RST;
            valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                max_records_reg <= cfg_data;
            end
            if (accept)
            begin
                valid_reg <= 1'b1;
            end
            else if (take)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg  <= data_next;
            limit_reg <= limit_next;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_data  = data_reg;
    assign stage_limit = limit_reg;

endmodule

`default_nettype wire

### rtl/core/fcd_fold.sv
// ----------------------------------------------------------------------------
// FNV-1a change detector: fold stage
// Keeps the running frame state, folds each kept word into the hash and
// closes the frame into the result register on the last word.
// ----------------------------------------------------------------------------
`default_nettype none

module fcd_fold #(
    parameter int unsigned WORDS_PER_RECORD = fcd_pkg::WORDS_PER_RECORD_DEF,
    localparam int unsigned WL_W =
        $clog2(fcd_pkg::RECORD_LIMIT * WORDS_PER_RECORD + 1)
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 stage_valid,
    input  fcd_pkg::seed_t      stage_data,
    input  wire  [WL_W-1:0]     stage_limit,
    output logic                take,
    input  wire                 out_free,
    output logic                res_valid,
    output fcd_pkg::frame_t     res_data
);

    import fcd_pkg::*;

    logic [DATA_W-1:0]  hash_reg;
    logic [WL_W-1:0]    seen_reg;
    logic [WL_W-1:0]    limit_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               trunc_reg;
    logic               res_valid_reg;
    frame_t             res_reg;

    logic [DATA_W-1:0]  base_hash;
    logic [WL_W-1:0]    base_seen;
    logic [WL_W-1:0]    base_limit;
    logic [COUNT_W-1:0] base_count;
    logic               base_trunc;
    logic               keep;
    logic [DATA_W-1:0]  hash_next;
    logic [WL_W-1:0]    seen_next;
    logic               res_ready;
    logic               close;

    // a frame start replaces the running state before its own word is folded
    always_comb
    begin
        base_hash  = stage_data.first_item ? stage_data.seed_hash    : hash_reg;
        base_seen  = stage_data.first_item ? '0                      : seen_reg;
        base_limit = stage_data.first_item ? stage_limit             : limit_reg;
        base_count = stage_data.first_item ? stage_data.kept_records : count_reg;
        base_trunc = stage_data.first_item ? stage_data.truncated    : trunc_reg;

        keep      = stage_data.has_word && (base_seen < base_limit);
        hash_next = keep ? fnv_mul(base_hash ^ stage_data.payload_word) : base_hash;
        seen_next = keep ? base_seen + WL_W'(1) : base_seen;
    end

    assign res_ready = !res_valid_reg || out_free;
    assign take      = stage_valid && (!stage_data.last_item || res_ready);
    assign close     = take && stage_data.last_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg      <= FNV_BASIS;
            seen_reg      <= '0;
            limit_reg     <= '0;
            count_reg     <= '0;
            trunc_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (close)
            begin
                // back to idle: unseeded basis, nothing kept
                hash_reg  <= FNV_BASIS;
                seen_reg  <= '0;
                limit_reg <= '0;
                count_reg <= '0;
                trunc_reg <= 1'b0;
            end
            else if (take)
            begin
                hash_reg  <= hash_next;
                seen_reg  <= seen_next;
                limit_reg <= base_limit;
                count_reg <= base_count;
                trunc_reg <= base_trunc;
            end

            if (close)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (out_free)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (close)
        begin
            res_reg.fingerprint  <= hash_next;
            res_reg.kept_records <= base_count;
            res_reg.truncated    <= base_trunc;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

endmodule

`default_nettype wire

### rtl/core/fcd_decide.sv
// ----------------------------------------------------------------------------
// FNV-1a change detector: decision stage
// Compares a closed frame with the last uploaded one, records it on a
// change and presents the result word in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fcd_decide (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 res_valid,
    input  fcd_pkg::frame_t     res_data,
    output logic                out_free,
    output logic                out_valid,
    input  wire                 out_stall,
    output fcd_pkg::out_word_t  out_data
);

    import fcd_pkg::*;

    logic [DATA_W-1:0]  prev_hash_reg;
    logic [COUNT_W-1:0] prev_count_reg;
    logic               prev_valid_reg;
    logic               out_valid_reg;
    out_word_t          out_reg;

    logic               same;
    logic               load;

    assign same = prev_valid_reg && (prev_hash_reg == res_data.fingerprint)
                  && (prev_count_reg == res_data.kept_records);

    assign out_free = !out_valid_reg || !out_stall;
    assign load     = res_valid && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_hash_reg  <= '0;
            prev_count_reg <= '0;
            prev_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_free)
            begin
                out_valid_reg <= res_valid;
            end
            // remember only frames that go out as uploads
            if (load && !same)
            begin
                prev_hash_reg  <= res_data.fingerprint;
                prev_count_reg <= res_data.kept_records;
                prev_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg.upload_needed <= !same;
            out_reg.fingerprint   <= res_data.fingerprint;
            out_reg.kept_records  <= res_data.kept_records;
            out_reg.truncated     <= res_data.truncated;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

### rtl/core/fcd_checker.sv
// ----------------------------------------------------------------------------
// FNV-1a change detector: port checker
// Watches the top-level ports for stall behaviour and result sanity.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fnv1a_change_detector_macros.svh"

module fcd_checker (
    input wire                 clk,
    input wire                 rst_n,
    input wire                 in_valid,
    input wire                 in_stall,
    input wire                 out_valid,
    input wire                 out_stall,
    input fcd_pkg::out_word_t  out_data
);

    import fcd_pkg::*;

    logic out_seen_reg;
    logic out_seen_next;

    assign out_seen_next = out_seen_reg || (out_valid && !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_seen_reg <= 1'b0;
        end
        else
        begin
            out_seen_reg <= out_seen_next;
        end
    end

    // a stalled result word holds
    `FCD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

    // a stalled input word stays offered
    `FCD_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid)

    // back-pressure on the input only ever comes from the output side
    `FCD_ASSERT_SAME(a_no_own_stall, !out_stall, !in_stall)

    // the count never exceeds the record limit
    `FCD_ASSERT_SAME(a_kept_range, out_valid, out_data.kept_records <= COUNT_LIMIT)

    // nothing has been uploaded before the first result, so it must upload
    `FCD_ASSERT_SAME(a_first_upload, out_valid && !out_seen_reg, out_data.upload_needed)

endmodule

bind fnv1a_change_detector fcd_checker u_fcd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire

### tb/tb.sv
// ----------------------------------------------------------------------------
// FNV-1a change detector: self-checking testbench
// Streams directed and random frames of record words through the detector
// and checks every decision against an in-bench fingerprint predictor. Runs
// through several max_records settings and mixes of sender gaps and receiver
// stalls.
// ----------------------------------------------------------------------------
module tb;

    import fcd_pkg::*;

    localparam int unsigned    WPR         = WORDS_PER_RECORD_DEF;
    localparam logic [63:0]    FNV_PRIME   = 64'h0000_0100_0000_01b3;
    localparam int             CYCLE_LIMIT = 200000;
    localparam int             PHASES      = 8;
    localparam int             PHASE_WORDS = 100;
    localparam int             SETTLE      = 8;

    typedef struct {
        in_word_t  word;
        bit        typed;
        out_word_t result;
    } script_row_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_write = 1'b0;
    logic [COUNT_W-1:0] cfg_data  = '0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    in_word_t           in_data   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    out_word_t          out_data;

    // fingerprint predictor state
    logic [COUNT_W-1:0] max_records   = MAX_RECORDS_RST;
    logic [63:0]        hash_acc      = FNV_BASIS;
    logic [17:0]        kept_words    = '0;
    logic [COUNT_W-1:0] frame_records = '0;
    logic               frame_cut     = 1'b0;
    logic [63:0]        last_hash     = '0;
    logic [COUNT_W-1:0] last_records  = '0;
    logic               last_valid    = 1'b0;

    out_word_t   awaited_results[$];
    in_word_t    last_frame[$];
    script_row_t script[$];

    int send_idle_pct  = 0;
    int sink_stall_pct = 0;
    int words_sent     = 0;
    int errors         = 0;
    int cycles         = 0;

    fnv1a_change_detector #(
        .WORDS_PER_RECORD (WPR)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
    end

    // advance the predictor by one accepted word
    task automatic fold_fingerprint(input in_word_t w, output bit produced,
                                    output out_word_t res);
        logic [COUNT_W-1:0] cap;
        bit                 same;
        produced = 1'b0;
        res      = '0;
        if (w.first_item)
        begin
            cap = (max_records > COUNT_LIMIT) ? COUNT_LIMIT : max_records;
            if (w.requested_records > {3'b000, cap})
            begin
                frame_records = cap;
                frame_cut     = 1'b1;
            end
            else
            begin
                frame_records = w.requested_records[COUNT_W-1:0];
                frame_cut     = 1'b0;
            end
            hash_acc   = (FNV_BASIS ^ 64'(frame_records)) * FNV_PRIME;
            kept_words = '0;
        end
        // drop words past the record limit
        if (w.has_word && (32'(kept_words) < 32'(frame_records) * WPR))
        begin
            hash_acc   = (hash_acc ^ w.payload_word) * FNV_PRIME;
            kept_words = kept_words + 18'd1;
        end
        if (w.last_item)
        begin
            same     = last_valid && last_hash == hash_acc
                       && last_records == frame_records;
            produced = 1'b1;
            res      = out_word_t'{!same, hash_acc, frame_records, frame_cut};
            if (!same)
            begin
                last_hash    = hash_acc;
                last_records = frame_records;
                last_valid   = 1'b1;
            end
            hash_acc      = FNV_BASIS;
            kept_words    = '0;
            frame_records = '0;
            frame_cut     = 1'b0;
        end
    endtask

    task automatic send_word(input in_word_t w, input bit typed, input out_word_t typed_res);
        bit        taken;
        bit        produced;
        out_word_t res;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        // hold the word until a cycle without stall
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        fold_fingerprint(w, produced, res);
        if (produced)
            awaited_results.push_back(typed ? typed_res : res);
        words_sent++;
    endtask

    task automatic wait_for_results(input int settle);
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_max_records(input logic [COUNT_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write   <= 1'b0;
        max_records = value;
    endtask

    function automatic logic [63:0] rand_payload();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic script_row_t row(input logic [63:0] data, input logic hw, f, l,
                                        input logic [15:0] req, input bit typed = 1'b0,
                                        input out_word_t result = '0);
        script_row_t r;
        r.word   = in_word_t'{data, hw, f, l, req};
        r.typed  = typed;
        r.result = result;
        return r;
    endfunction

    task automatic send_frame();
        in_word_t frame_q[$];
        in_word_t w;
        int       kind;
        int       req;
        int       n;
        int       span;
        kind = $urandom_range(0, 99);
        if (kind < 12 && last_frame.size() > 0)
            frame_q = last_frame;
        else if (kind < 24)
        begin
            w = in_word_t'{rand_payload(), 1'($urandom), 1'($urandom), 1'($urandom),
                           16'($urandom)};
            frame_q.push_back(w);
        end
        else
        begin
            case ($urandom_range(0, 9)) inside
                [0:5]:   req = $urandom_range(0, 3);
                [6:7]:   req = $urandom_range(4, 64);
                8:       req = $urandom_range(0, 65535);
                default:
                begin
                    if ($urandom_range(0, 1) != 0)
                        req = 65535;
                    else
                        req = 4096 + $urandom_range(0, 1);
                end
            endcase
            span = req * WPR + 2;
            if (span > 40)
                span = 40;
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, span) : $urandom_range(0, 6);
            for (int i = 0; i <= n; i++)
            begin
                w.payload_word      = rand_payload();
                w.has_word          = ($urandom_range(0, 9) != 0);
                w.first_item        = (i == 0);
                w.last_item         = (i == n);
                w.requested_records = (i == 0) ? 16'(req) : 16'($urandom);
                frame_q.push_back(w);
            end
            // leave some frames open so the next start discards them
            if (kind >= 90)
                frame_q[n].last_item = 1'b0;
            else
                last_frame = frame_q;
        end
        foreach (frame_q[i])
            send_word(frame_q[i], 1'b0, '0);
    endtask

    // results are taken at the next rising edge; sample them mid-cycle
    always @(negedge clk)
    begin
        out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: upload=%0b fp=%h kept=%0d trunc=%0b",
                             out_data.upload_needed, out_data.fingerprint,
                             out_data.kept_records, out_data.truncated);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (want.upload_needed !== out_data.upload_needed
                    || want.fingerprint !== out_data.fingerprint
                    || want.kept_records !== out_data.kept_records
                    || want.truncated !== out_data.truncated)
                begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: expected upload=%0b fp=%h kept=%0d trunc=%0b,",
                                  " got upload=%0b fp=%h kept=%0d trunc=%0b"},
                                 want.upload_needed, want.fingerprint,
                                 want.kept_records, want.truncated,
                                 out_data.upload_needed, out_data.fingerprint,
                                 out_data.kept_records, out_data.truncated);
                end
            end
        end
    end

    initial
    begin
        logic [COUNT_W-1:0] limits [PHASES];
        logic [COUNT_W-1:0] lim;
        int                 target;

        limits = '{13'd0, 13'd4096, 13'd8191, 13'd1, 13'd2, 13'd1024, 13'd0, 13'd3};

        // last word with no frame open, then the same again
        script.push_back(row('0, 1'b0, 1'b0, 1'b1, 16'h0000, 1'b1,
                             out_word_t'{1'b1, FNV_BASIS, 13'd0, 1'b0}));
        script.push_back(row('0, 1'b0, 1'b0, 1'b1, 16'h0000, 1'b1,
                             out_word_t'{1'b0, FNV_BASIS, 13'd0, 1'b0}));
        script.push_back(row('1, 1'b1, 1'b0, 1'b0, 16'hffff));
        script.push_back(row('1, 1'b1, 1'b1, 1'b1, 16'h0000));
        script.push_back(row('1, 1'b1, 1'b1, 1'b0, 16'hffff));
        script.push_back(row('0, 1'b0, 1'b0, 1'b1, 16'h0000));
        // restart inside a frame, then run past the word limit of one record
        script.push_back(row(64'h0123_4567_89ab_cdef, 1'b1, 1'b1, 1'b0, 16'h0002));
        script.push_back(row(64'hfedc_ba98_7654_3210, 1'b1, 1'b1, 1'b0, 16'h0001));
        for (int i = 0; i < WPR - 1; i++)
            script.push_back(row({$urandom, $urandom}, 1'b1, 1'b0, 1'b0, 16'($urandom)));
        script.push_back(row(64'h5555_5555_5555_5555, 1'b1, 1'b0, 1'b1, 16'h0000));
        script.push_back(row('0, 1'b0, 1'b1, 1'b1, 16'h0003));
        script.push_back(row('0, 1'b0, 1'b1, 1'b1, 16'h0003));
        script.push_back(row('0, 1'b0, 1'b0, 1'b1, 16'h0000, 1'b1,
                             out_word_t'{1'b1, FNV_BASIS, 13'd0, 1'b0}));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
            send_word(script[i].word, script[i].typed, script[i].result);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_for_results(SETTLE);
            lim = (phase == 6) ? 13'($urandom_range(0, 8191)) : limits[phase];
            write_max_records(lim);
            case (phase % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 57;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    sink_stall_pct = 57;
                end
                default:
                begin
                    send_idle_pct  = 34;
                    sink_stall_pct = 34;
                end
            endcase
            target = words_sent + PHASE_WORDS;
            while (words_sent < target)
                send_frame();
        end

        wait_for_results(SETTLE + 2);
        if (awaited_results.size() != 0)
            errors++;
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
